/* src/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication with the consequent checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/apq_pkg.sv */
package apq_pkg;
	localparam int LEVELS = 4;
	localparam int CAPACITY = 16;
	localparam int LVW = $clog2(LEVELS);
	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(LEVELS * CAPACITY);

	localparam logic [2:0] ST_PUBLISHED = 3'd0;
	localparam logic [2:0] ST_BAD_LEVEL = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_DEQUEUED  = 3'd4;

	localparam logic [15:0] LIFE_RESET = 16'd10;

	typedef enum logic [2:0] {
		S_IDLE, S_PUSH, S_POP_RD, S_POP, S_SW_RD, S_SW_CHK, S_OUT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load_in;     // capture request
		logic push;        // write input entry to level tail
		logic pop_rd;      // read head of found level
		logic pop;         // commit pop and stamp++
		logic sw_start;    // begin sweep at level 0
		logic sw_rd;       // read head of sweep level
		logic sw_move;     // promote head
		logic sw_next;     // advance sweep level
		logic set_res;     // set result from status
		logic [2:0] res_status;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic is_deq;
		logic bad_level;
		logic full;
		logic any;
		logic sw_nonempty;
		logic sw_old;
		logic sw_last;
	} stat_t;
endpackage

/* src/apq_datapath.sv */
module apq_datapath import apq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [27:0] in_data,
	input  logic [15:0] life_time,
	output logic [2:0]  res_status,
	output logic [7:0]  res_id,
	output logic [15:0] res_tag,
	output logic [2:0]  res_level
);
	logic [39:0] mem [LEVELS*CAPACITY];
	logic [39:0] rd_q;
	logic [PW-1:0] head_q [LEVELS];
	logic [CW-1:0] cnt_q [LEVELS];
	logic [CW-1:0] total_q;
	logic [15:0] stamp_q;
	logic        mode_q;
	logic [7:0]  id_q;
	logic [2:0]  lvl_q;
	logic [15:0] tag_q;
	logic [LVW-1:0] sel_q;
	logic [LVW-1:0] first_lv;
	logic [LVW-1:0] dst_lv;
	logic [LVW-1:0] wr_lv;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [39:0] wr_data;
	logic        wr_en;
	logic [15:0] lim, age;

	// priority search for most urgent non-empty level
	always_comb begin
		first_lv = '0;
		st.any = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				first_lv = LVW'(i);
				st.any = 1'b1;
			end
		end
	end

	assign lim = (life_time == '0) ? 16'd1 : life_time;
	assign age = stamp_q - rd_q[39:24];
	assign dst_lv = (sel_q == '0) ? '0 : sel_q - 1'b1;
	assign st.is_deq = mode_q;
	assign st.bad_level = 32'(lvl_q) >= LEVELS;
	assign st.full = 32'(total_q) >= CAPACITY;
	assign st.sw_nonempty = cnt_q[sel_q] != '0;
	assign st.sw_old = age >= lim;
	assign st.sw_last = 32'(sel_q) == LEVELS - 1;

	assign rd_addr = AW'(32'(sel_q) * CAPACITY + 32'(head_q[sel_q]));
	assign wr_lv = cmd.push ? LVW'(lvl_q) : dst_lv;
	assign wr_addr = AW'(32'(wr_lv) * CAPACITY
		+ ((32'(head_q[wr_lv]) + 32'(cnt_q[wr_lv])) % CAPACITY));
	assign wr_data = cmd.push ? {stamp_q, tag_q, id_q} : {stamp_q, rd_q[23:0]};
	assign wr_en = cmd.push | cmd.sw_move;

	// entry store
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// request capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= in_data[0];
			id_q   <= in_data[8:1];
			lvl_q  <= in_data[11:9];
			tag_q  <= in_data[27:12];
		end
		if (cmd.set_res) begin
			res_status <= cmd.res_status;
			res_id <= '0;
			res_tag <= '0;
			res_level <= '0;
		end
		if (cmd.pop) begin
			res_status <= ST_DEQUEUED;
			res_id <= rd_q[7:0];
			res_tag <= rd_q[23:8];
			res_level <= 3'(sel_q);
		end
	end

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			total_q <= '0;
			stamp_q <= '0;
			sel_q <= '0;
		end else begin
			if (cmd.pop_rd) sel_q <= first_lv;
			if (cmd.sw_start) sel_q <= '0;
			if (cmd.sw_next) sel_q <= sel_q + 1'b1;
			if (cmd.push) begin
				cnt_q[lvl_q[LVW-1:0]] <= cnt_q[lvl_q[LVW-1:0]] + 1'b1;
				total_q <= total_q + 1'b1;
			end
			if (cmd.pop) begin
				head_q[sel_q] <= PW'((32'(head_q[sel_q]) + 1) % CAPACITY);
				cnt_q[sel_q] <= cnt_q[sel_q] - 1'b1;
				total_q <= total_q - 1'b1;
				stamp_q <= stamp_q + 1'b1;
			end
			if (cmd.sw_move) begin
				head_q[sel_q] <= PW'((32'(head_q[sel_q]) + 1) % CAPACITY);
				if (dst_lv != sel_q) begin
					cnt_q[sel_q] <= cnt_q[sel_q] - 1'b1;
					cnt_q[dst_lv] <= cnt_q[dst_lv] + 1'b1;
				end
			end
		end
	end
endmodule

/* src/apq_ctrl.sv */
module apq_ctrl import apq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_fire,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	input  stat_t  st,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load_in = 1'b1;
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (st.is_deq) begin
					if (st.any) begin
						cmd.pop_rd = 1'b1;
						state_d = S_POP_RD;
					end else begin
						cmd.set_res = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_d = S_OUT;
					end
				end else begin
					cmd.set_res = 1'b1;
					state_d = S_OUT;
					if (st.bad_level) cmd.res_status = ST_BAD_LEVEL;
					else if (st.full) cmd.res_status = ST_FULL;
					else begin
						cmd.res_status = ST_PUBLISHED;
						cmd.push = 1'b1;
					end
				end
			end
			S_POP_RD: state_d = S_POP;
			S_POP: begin
				cmd.pop = 1'b1;
				cmd.sw_start = 1'b1;
				state_d = S_SW_RD;
			end
			S_SW_RD: begin
				if (st.sw_nonempty) state_d = S_SW_CHK;
				else if (st.sw_last) state_d = S_OUT;
				else cmd.sw_next = 1'b1;
			end
			S_SW_CHK: begin
				if (st.sw_old) begin
					cmd.sw_move = 1'b1;
					state_d = S_SW_RD;
				end else if (st.sw_last) state_d = S_OUT;
				else begin
					cmd.sw_next = 1'b1;
					state_d = S_SW_RD;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* src/aging_priority_event_queue.sv */
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | mode, event_id, priority_level, payload_tag | -
// m_axis  | out | status, out_event_id, out_payload_tag,      | -
//         |     | out_level                                   |
// cfg     | in  | APB, life_time at address 0                 | -
// A publish or empty dequeue goes through S_PUSH to S_OUT, then waits for the output handshake.
// A dequeue goes through S_PUSH, S_POP_RD and S_POP, then sweeps the levels in S_SW_RD and,
// for a non-empty level, S_SW_CHK, promoting aged heads; the registered store read sets this pace.
// Reset clears all counts, heads, stamp and life_time (to 10).
// One request at a time; input is not taken while a result waits.
module aging_priority_event_queue import apq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // mode, event_id, priority_level, payload_tag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status, out_event_id, out_payload_tag, out_level
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cmd_t  cmd;
	stat_t st;
	logic [15:0] life_q;
	logic [2:0]  r_status, r_level;
	logic [7:0]  r_id;
	logic [15:0] r_tag;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {16'd0, life_q} : 32'd0;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) life_q <= LIFE_RESET;
		else if (psel && penable && pwrite && paddr == 1'b0) life_q <= pwdata[15:0];
	end

	apq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_axis_tvalid & s_axis_tready),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.st, .cmd
	);

	apq_datapath u_dp (
		.clk, .arst_n, .cmd, .st,
		.in_data(s_axis_tdata[27:0]),
		.life_time(life_q),
		.res_status(r_status), .res_id(r_id), .res_tag(r_tag), .res_level(r_level)
	);

	assign m_axis_tdata = {2'b00, r_level, r_tag, r_id, r_status};
endmodule

/* src/apq_checker.sv */
`include "assert_macros.svh"
module apq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	`CHK_IMPL(a_excl, clk, arst_n, m_axis_tvalid, !s_axis_tready, "ready while result waits")
	`CHK_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
	`CHK_IMPL(a_stat, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4, "bad status")
	`CHK_IMPL(a_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[2:0] != 3'd4,
		m_axis_tdata[29:3] == 27'd0, "fields set on non-dequeue")
endmodule

bind aging_priority_event_queue apq_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
